// ===== src/twb_pkg.sv =====
// Shared types and constants for the transactional write buffer.
`timescale 1ns / 1ps
`default_nettype none
package twb_pkg;

  localparam int TWB_LOG_DEPTH = 64;
  localparam int ADDR_W        = 48;
  localparam int VALUE_W       = 64;
  localparam int FILTER_W      = 32;
  localparam int FILTER_SEL_W  = 5;
  localparam int HASH_SHIFT_A  = 2;
  localparam int HASH_SHIFT_B  = 5;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_STORE  = 2'd1,
    OP_LOAD   = 2'd2,
    OP_COMMIT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_BEGUN     = 3'd0,
    KIND_STORED    = 3'd1,
    KIND_OVERFLOW  = 3'd2,
    KIND_HIT       = 3'd3,
    KIND_MISS      = 3'd4,
    KIND_WRITEBACK = 3'd5,
    KIND_EMPTY     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_TOP  = 3'd1,
    PTR_ZERO = 3'd2,
    PTR_DEC  = 3'd3,
    PTR_INC  = 3'd4
  } ptr_op_t;

  typedef enum logic [1:0] {
    ASEL_INPUT = 2'd0,
    ASEL_HELD  = 2'd1,
    ASEL_ENTRY = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      capture;
    logic      append;
    logic      clear;
    logic      emit;
    kind_t     kind;
    addr_sel_t addr_sel;
    logic      val_entry;
    logic      last;
    ptr_op_t   ptr_op;
  } twb_cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic filter_hit;
    logic fill_zero;
    logic full;
    logic match;
    logic ptr_zero;
    logic ptr_last;
    logic out_free;
  } twb_status_t;

endpackage
`default_nettype wire

// ===== src/twb_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface twb_req_if import twb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [ADDR_W-1:0]         address;
  logic signed [VALUE_W-1:0] store_value;

  modport source (output valid, output opcode, output address, output store_value,
                  input ready);
  modport sink   (input valid, input opcode, input address, input store_value,
                  output ready);
endinterface

interface twb_rsp_if import twb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                kind;
  logic [ADDR_W-1:0]         out_address;
  logic signed [VALUE_W-1:0] out_value;
  logic                      last;

  modport source (output valid, output kind, output out_address, output out_value,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_address, input out_value,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== src/twb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module twb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/twb_datapath.sv =====
// Log storage, fill count, address filter, walk pointer and result register.
`timescale 1ns / 1ps
`default_nettype none
module twb_datapath import twb_pkg::*; #(
  parameter int LOG_DEPTH = TWB_LOG_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [1:0]                opcode,
  input  wire logic [ADDR_W-1:0]         address,
  input  wire logic signed [VALUE_W-1:0] store_value,
  input  wire twb_cmd_t                  cmd,
  output twb_status_t                    status,
  twb_rsp_if.source                      result
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int EW = ADDR_W + VALUE_W;

  logic [CW-1:0]             fill;
  logic [FILTER_W-1:0]       filter;
  logic [AW-1:0]             ptr;
  logic [AW-1:0]             ptr_next;
  logic [ADDR_W-1:0]         held_addr;
  logic [FILTER_SEL_W-1:0]   sel;
  logic [EW-1:0]             rd_data;
  logic [ADDR_W-1:0]         entry_addr;
  logic [VALUE_W-1:0]        entry_value;

  logic                      out_valid;
  kind_t                     out_kind;
  logic [ADDR_W-1:0]         out_address;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;
  logic [ADDR_W-1:0]         addr_mux;

  assign sel = address[HASH_SHIFT_A +: FILTER_SEL_W] ^ address[HASH_SHIFT_B +: FILTER_SEL_W];
  assign entry_addr  = rd_data[EW-1:VALUE_W];
  assign entry_value = rd_data[VALUE_W-1:0];

  // next pointer doubles as the RAM read address, so the registered read data lines up with ptr
  always_comb begin
    unique case (cmd.ptr_op)
      PTR_HOLD: ptr_next = ptr;
      PTR_TOP:  ptr_next = AW'(fill - CW'(1));
      PTR_ZERO: ptr_next = '0;
      PTR_DEC:  ptr_next = ptr - AW'(1);
      PTR_INC:  ptr_next = ptr + AW'(1);
      default:  ptr_next = ptr;
    endcase
  end

  twb_ram #(
    .WIDTH (EW),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (fill[AW-1:0]),
    .wr_data ({address, store_value}),
    .rd_addr (ptr_next),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      filter <= '0;
    end else if (cmd.clear) begin
      fill   <= '0;
      filter <= '0;
    end else if (cmd.append) begin
      fill        <= fill + CW'(1);
      filter[sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.capture) begin
      held_addr <= address;
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      ASEL_INPUT: addr_mux = address;
      ASEL_HELD:  addr_mux = held_addr;
      ASEL_ENTRY: addr_mux = entry_addr;
      default:    addr_mux = address;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind    <= cmd.kind;
      out_last    <= cmd.last;
      out_address <= addr_mux;
      out_value   <= cmd.val_entry ? signed'(entry_value) : '0;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.out_address = out_address;
  assign result.out_value   = out_value;
  assign result.last        = out_last;

  assign status.opcode     = op_t'(opcode);
  assign status.filter_hit = filter[sel];
  assign status.fill_zero  = (fill == '0);
  assign status.full       = (fill == CW'(LOG_DEPTH));
  assign status.match      = (entry_addr == held_addr);
  assign status.ptr_zero   = (ptr == '0);
  assign status.ptr_last   = ((CW'(ptr) + CW'(1)) == fill);
  assign status.out_free   = !out_valid || result.ready;

endmodule
`default_nettype wire

// ===== src/twb_ctrl.sv =====
// Sequencer: dispatches each request and walks the log for loads and commits.
`timescale 1ns / 1ps
`default_nettype none
module twb_ctrl import twb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire twb_status_t status,
  output twb_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.kind     = KIND_BEGUN;
    cmd.addr_sel = ASEL_INPUT;
    cmd.ptr_op   = PTR_HOLD;
    state_next   = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cmd.last    = 1'b1;
          unique case (status.opcode)
            OP_BEGIN: begin
              cmd.clear = 1'b1;
              cmd.emit  = 1'b1;
              cmd.kind  = KIND_BEGUN;
            end
            OP_STORE: begin
              cmd.emit = 1'b1;
              if (status.full) begin
                cmd.kind = KIND_OVERFLOW;
              end else begin
                cmd.append = 1'b1;
                cmd.kind   = KIND_STORED;
              end
            end
            OP_LOAD: begin
              if (status.filter_hit && !status.fill_zero) begin
                cmd.ptr_op = PTR_TOP;
                state_next = ST_SEARCH;
              end else begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_MISS;
              end
            end
            OP_COMMIT: begin
              if (status.fill_zero) begin
                cmd.clear = 1'b1;
                cmd.emit  = 1'b1;
                cmd.kind  = KIND_EMPTY;
              end else begin
                cmd.ptr_op = PTR_ZERO;
                state_next = ST_DRAIN;
              end
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // newest to oldest; result register is free here
        cmd.addr_sel = ASEL_HELD;
        cmd.last     = 1'b1;
        if (status.match) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_HIT;
          cmd.val_entry = 1'b1;
          state_next    = ST_IDLE;
        end else if (status.ptr_zero) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_MISS;
          state_next = ST_IDLE;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      ST_DRAIN: begin
        cmd.addr_sel  = ASEL_ENTRY;
        cmd.kind      = KIND_WRITEBACK;
        cmd.val_entry = 1'b1;
        cmd.last      = status.ptr_last;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.ptr_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.ptr_op = PTR_INC;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/transactional_write_buffer.sv =====
// Top level of the transactional write buffer.
`timescale 1ns / 1ps
`default_nettype none
// Deferred-store log for one transaction with a 32-bit address filter. Begin, store,
// a load whose filter bit is clear and an empty commit are each answered straight from idle; the
// result beat sits in the output register from the next cycle and a new request is
// taken as soon as that register is free or being emptied. A load whose filter bit
// is set walks the log newest first through the log RAM read port, one entry a
// cycle. A non-empty commit produces one writeback beat per entry, oldest first, at one
// beat a cycle while the consumer keeps ready high. Log entries hold no reset value;
// the fill count alone decides what is live, so no clearing pass follows reset.
module transactional_write_buffer import twb_pkg::*; #(
  parameter int LOG_DEPTH = TWB_LOG_DEPTH
) (
  input wire logic  clk,
  input wire logic  rst,
  twb_req_if.sink   request,
  twb_rsp_if.source result
);

  twb_cmd_t    cmd;
  twb_status_t status;
  logic        in_ready;

  assign request.ready = in_ready;

  twb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  twb_datapath #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .opcode      (request.opcode),
    .address     (request.address),
    .store_value (request.store_value),
    .cmd         (cmd),
    .status      (status),
    .result      (result)
  );

endmodule
`default_nettype wire

// ===== src/twb_checker.sv =====
// Port-level checks for the transactional write buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module twb_checker import twb_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_ready,
  input wire logic [1:0]                req_opcode,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic [2:0]                rsp_kind,
  input wire logic [ADDR_W-1:0]         rsp_address,
  input wire logic signed [VALUE_W-1:0] rsp_value,
  input wire logic                      rsp_last
);

  logic req_beat;
  logic rsp_beat;

  assign req_beat = req_valid && req_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_address)
                                && $stable(rsp_value) && $stable(rsp_last))
    else $error("result beat changed while stalled");

  // no request taken while a result is stuck in the output register
  a_no_take_blocked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken with blocked result");

  a_begin_answer: assert property (@(posedge clk) disable iff (rst)
    req_beat && (req_opcode == OP_BEGIN) |=> rsp_valid && (rsp_kind == KIND_BEGUN) && rsp_last)
    else $error("begin not answered next cycle");

  // drain keeps streaming while the consumer is ready
  a_drain_stream: assert property (@(posedge clk) disable iff (rst)
    rsp_beat && (rsp_kind == KIND_WRITEBACK) && !rsp_last
      |=> rsp_valid && (rsp_kind == KIND_WRITEBACK))
    else $error("writeback stream broken");

endmodule

bind transactional_write_buffer twb_checker u_twb_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_opcode  (request.opcode),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .rsp_kind    (result.kind),
  .rsp_address (result.out_address),
  .rsp_value   (result.out_value),
  .rsp_last    (result.last)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the transactional write buffer: table, then random.
`timescale 1ns / 1ps
module tb;
  import twb_pkg::*;

  localparam int RANDOM_ITEMS = 148;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    kind_t  kind;
    addr_t  addr;
    value_t value;
    logic   last;
  } beat_t;

  typedef struct {
    op_t    op;
    addr_t  addr;
    value_t value;
    bit     typed;
    kind_t  kind;
    addr_t  exp_addr;
    value_t exp_value;
  } stim_row_t;

  localparam addr_t  AMAX = 48'hFFFF_FFFF_FFFF;
  localparam value_t VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam value_t VMIN = 64'h8000_0000_0000_0000;

  localparam int DIRECTED = 22;
  // typed rows carry their own expectation; the others go through the shadow log
  stim_row_t directed_rows [DIRECTED] = '{
    '{OP_STORE,  48'h0,            VMAX,                  1, KIND_STORED, 48'h0, 64'h0},
    '{OP_LOAD,   48'h0,            64'h5555,              0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_BEGIN,  AMAX,             -64'sd1,               1, KIND_BEGUN,  AMAX,  64'h0},
    '{OP_LOAD,   48'h0,            64'h0,                 1, KIND_MISS,   48'h0, 64'h0},
    '{OP_STORE,  AMAX,             VMIN,                  1, KIND_STORED, AMAX,  64'h0},
    '{OP_STORE,  48'h100,          -64'sd1,               1, KIND_STORED, 48'h100, 64'h0},
    '{OP_STORE,  48'h200,          64'h0,                 0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_LOAD,   AMAX,             64'h0,                 0, KIND_BEGUN,  48'h0, 64'h0},
    // same filter bit as 0x100, different word: miss with the bit set
    '{OP_LOAD,   48'h101,          64'h0,                 0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_LOAD,   48'h8000_0000_0100, 64'h0,               0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_STORE,  48'h100,          64'h0123_4567_89AB_CDEF, 0, KIND_BEGUN, 48'h0, 64'h0},
    '{OP_LOAD,   48'h100,          64'h0,                 0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_LOAD,   48'h4,            64'h0,                 0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_COMMIT, 48'h5A5A,         64'd123,               0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_COMMIT, 48'hABCD_EF01_2345, -64'sd1,             1, KIND_EMPTY,  48'hABCD_EF01_2345,
      64'h0},
    '{OP_LOAD,   AMAX,             64'h0,                 1, KIND_MISS,   AMAX,  64'h0},
    '{OP_STORE,  48'h3FC,          64'h1,                 0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_BEGIN,  48'h0,            64'h5555_AAAA_5555_AAAA, 1, KIND_BEGUN, 48'h0, 64'h0},
    '{OP_COMMIT, 48'h0,            64'h0,                 1, KIND_EMPTY,  48'h0, 64'h0},
    '{OP_STORE,  48'h7FFF_FFFF_FFF8, -64'sd2,             0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_COMMIT, AMAX,             64'h0,                 0, KIND_BEGUN,  48'h0, 64'h0},
    '{OP_LOAD,   48'h7FFF_FFFF_FFF8, 64'h0,               1, KIND_MISS,   48'h7FFF_FFFF_FFF8,
      64'h0}
  };

  logic clk = 1'b0;
  logic rst;

  twb_req_if req_ch ();
  twb_rsp_if rsp_ch ();

  transactional_write_buffer uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the log
  addr_t       shadow_addr [TWB_LOG_DEPTH];
  value_t      shadow_val  [TWB_LOG_DEPTH];
  int          shadow_fill;
  logic [31:0] shadow_filter;

  beat_t step_beats [$];
  beat_t owed_beats [$];
  beat_t head_beat;

  int fail_count   = 0;
  int sent_count   = 0;
  int beat_count   = 0;
  int cycle_count  = 0;
  int burst_left   = 0;
  int kind_seen [7];

  int   rx_mode      = 0;
  int   rx_mode_left = 0;
  int   rx_hold      = 0;
  logic rx_level     = 1'b1;

  function automatic logic [4:0] filter_index(addr_t a);
    return a[6:2] ^ a[9:5];
  endfunction

  function automatic void apply_buffer_op(op_t op, addr_t a, value_t v);
    bit     found;
    value_t fwd;
    found = 1'b0;
    fwd   = '0;
    step_beats.delete();
    case (op)
      OP_BEGIN: begin
        shadow_fill   = 0;
        shadow_filter = '0;
        step_beats.push_back('{KIND_BEGUN, a, '0, 1'b1});
      end
      OP_STORE: begin
        if (shadow_fill >= TWB_LOG_DEPTH) begin
          step_beats.push_back('{KIND_OVERFLOW, a, '0, 1'b1});
        end else begin
          shadow_filter[filter_index(a)] = 1'b1;
          shadow_addr[shadow_fill] = a;
          shadow_val[shadow_fill]  = v;
          shadow_fill++;
          step_beats.push_back('{KIND_STORED, a, '0, 1'b1});
        end
      end
      OP_LOAD: begin
        if (shadow_filter[filter_index(a)]) begin
          for (int i = shadow_fill - 1; i >= 0; i--) begin
            if (!found && shadow_addr[i] == a) begin
              found = 1'b1;
              fwd   = shadow_val[i];
            end
          end
        end
        if (found) step_beats.push_back('{KIND_HIT, a, fwd, 1'b1});
        else step_beats.push_back('{KIND_MISS, a, '0, 1'b1});
      end
      default: begin
        if (shadow_fill == 0) begin
          step_beats.push_back('{KIND_EMPTY, a, '0, 1'b1});
        end else begin
          for (int i = 0; i < shadow_fill; i++)
            step_beats.push_back('{KIND_WRITEBACK, shadow_addr[i], shadow_val[i],
                                   (i == shadow_fill - 1)});
        end
        shadow_fill   = 0;
        shadow_filter = '0;
      end
    endcase
  endfunction

  function automatic addr_t rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return AMAX;
      2:       return {w[47:10], 10'h0};
      default: return w[ADDR_W-1:0];
    endcase
  endfunction

  function automatic value_t rand_word();
    case ($urandom_range(0, 9))
      0:       return VMIN;
      1:       return VMAX;
      2:       return '0;
      3:       return -64'sd1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // load addresses: mostly live words, some filter aliases, some strangers
  function automatic addr_t pick_load_addr(addr_t pool [6]);
    addr_t a;
    a = pool[$urandom_range(0, 5)];
    case ($urandom_range(0, 9))
      0, 1:    return a ^ (48'h1 << $urandom_range(10, ADDR_W - 1));
      2:       return a ^ 48'(1 << $urandom_range(0, 1));
      3, 4:    return rand_addr();
      default: return a;
    endcase
  endfunction

  task automatic send_request(op_t op, addr_t a, value_t v, bit typed = 1'b0,
                              beat_t typed_beat = '0);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(30, 60);
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(0, 8);
      end
    end
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.address     <= a;
    req_ch.store_value <= v;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    sent_count++;
    apply_buffer_op(op, a, v);
    if (typed) owed_beats.push_back(typed_beat);
    else foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
  endtask

  // begin, a body of stores and loads on a small address pool, commit
  task automatic run_transaction(int n_ops, bit fill_up);
    addr_t pool [6];
    int    n_stores;
    foreach (pool[k]) pool[k] = rand_addr();
    send_request(OP_BEGIN, rand_addr(), rand_word());
    if (fill_up) begin
      // run the log past full so that the trailing stores overflow
      n_stores = TWB_LOG_DEPTH + $urandom_range(1, 4);
      for (int k = 0; k < n_stores; k++) begin
        send_request(OP_STORE, ($urandom_range(0, 1) ? pool[$urandom_range(0, 5)]
                                                      : rand_addr()), rand_word());
        if (k % 16 == 15) send_request(OP_LOAD, pick_load_addr(pool), rand_word());
      end
      repeat (3) send_request(OP_LOAD, pick_load_addr(pool), rand_word());
    end else begin
      repeat (n_ops) begin
        if ($urandom_range(0, 1))
          send_request(OP_STORE, pool[$urandom_range(0, 5)], rand_word());
        else
          send_request(OP_LOAD, pick_load_addr(pool), rand_word());
      end
    end
    send_request(OP_COMMIT, rand_addr(), rand_word());
  endtask

  // noise: anything goes, including ops outside a transaction
  task automatic run_noise(int n_ops);
    repeat (n_ops) send_request(op_t'($urandom_range(0, 3)), rand_addr(), rand_word());
  endtask

  // result sink: always ready, random stalls, or stall bursts
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 200);
    end
    rx_mode_left--;
    if (rx_hold == 0) begin
      rx_level = !rx_level;
      rx_hold  = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 7);
    end
    rx_hold--;
    case (rx_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= ($urandom_range(0, 2) != 0);
      default: rsp_ch.ready <= rx_level;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_beats.size() == 0) begin
        $error("result beat with nothing outstanding: kind %0d address %h value %h",
               rsp_ch.kind, rsp_ch.out_address, rsp_ch.out_value);
        fail_count++;
      end else begin
        head_beat = owed_beats.pop_front();
        beat_count++;
        kind_seen[head_beat.kind]++;
        if (rsp_ch.kind !== head_beat.kind) begin
          $error("kind: expected %0d, got %0d", head_beat.kind, rsp_ch.kind);
          fail_count++;
        end
        if (rsp_ch.out_address !== head_beat.addr) begin
          $error("out_address: expected %h, got %h", head_beat.addr, rsp_ch.out_address);
          fail_count++;
        end
        if (rsp_ch.out_value !== head_beat.value) begin
          $error("out_value: expected %h, got %h", head_beat.value, rsp_ch.out_value);
          fail_count++;
        end
        if (rsp_ch.last !== head_beat.last) begin
          $error("last: expected %0d, got %0d", head_beat.last, rsp_ch.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("transactional_write_buffer regression: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        pick;
    bit        first;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_BEGIN;
    req_ch.address     = '0;
    req_ch.store_value = '0;
    shadow_fill        = 0;
    shadow_filter      = '0;
    first              = 1'b1;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.op, row.addr, row.value, row.typed,
                   '{row.kind, row.exp_addr, row.exp_value, 1'b1});
    end

    while (sent_count < DIRECTED + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (first || pick < 6) run_transaction(0, 1'b1);
      else if (pick < 80) run_transaction($urandom_range(0, 10), 1'b0);
      else run_noise($urandom_range(1, 6));
      first = 1'b0;
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (TWB_LOG_DEPTH + 16) @(posedge clk);

    $display("%0d requests (%0d from the table), %0d result beats checked", sent_count,
             DIRECTED, beat_count);
    $display("hits %0d, misses %0d, overflows %0d, writebacks %0d, empty commits %0d",
             kind_seen[KIND_HIT], kind_seen[KIND_MISS], kind_seen[KIND_OVERFLOW],
             kind_seen[KIND_WRITEBACK], kind_seen[KIND_EMPTY]);
    if (fail_count == 0) begin
      $display("transactional_write_buffer regression: pass");
    end else begin
      $display("transactional_write_buffer regression: fail");
    end
    $finish;
  end

endmodule
